// File: sv/assert_macros.svh
// Assertion macros used by the top level of the gzip header parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a clocked property, disabled while reset is asserted.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, expr, msg)

`endif

`endif

// File: sv/gzhp_pkg.sv
// Types, constants and helper functions for the gzip header parser.
`default_nettype none

package gzhp_pkg;

	// Header constants
	localparam logic [7:0]  GZ_ID1        = 8'h1F;
	localparam logic [7:0]  GZ_ID2        = 8'h8B;
	localparam logic [7:0]  GZ_CM_DEFLATE = 8'd8;
	localparam logic [7:0]  GZ_FHCRC      = 8'h02;
	localparam logic [7:0]  GZ_FEXTRA     = 8'h04;
	localparam logic [7:0]  GZ_FNAME      = 8'h08;
	localparam logic [7:0]  GZ_FCOMMENT   = 8'h10;
	localparam logic [7:0]  GZ_RESERVED   = 8'hE0;
	localparam logic [3:0]  GZ_FIXED_LEN  = 4'd10;
	localparam logic [15:0] LIMIT_RESET   = 16'd1024;
	localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;

	// Field positions inside the fixed header
	localparam logic [3:0] IDX_ID1   = 4'd0;
	localparam logic [3:0] IDX_ID2   = 4'd1;
	localparam logic [3:0] IDX_CM    = 4'd2;
	localparam logic [3:0] IDX_FLAGS = 4'd3;

	// Optional-field stages already consumed
	localparam logic [1:0] DONE_FIXED   = 2'd0;
	localparam logic [1:0] DONE_EXTRA   = 2'd1;
	localparam logic [1:0] DONE_NAME    = 2'd2;
	localparam logic [1:0] DONE_COMMENT = 2'd3;

	typedef enum logic [3:0] {
		PH_FIXED   = 4'd0,
		PH_XLEN_LO = 4'd1,
		PH_XLEN_HI = 4'd2,
		PH_EXTRA   = 4'd3,
		PH_NAME    = 4'd4,
		PH_COMMENT = 4'd5,
		PH_HCRC_LO = 4'd6,
		PH_HCRC_HI = 4'd7,
		PH_PAYLOAD = 4'd8,
		PH_ENDED   = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		ST_PENDING     = 3'd0,
		ST_COMPLETE    = 3'd1,
		ST_PAYLOAD     = 3'd2,
		ST_UNSUPPORTED = 3'd3,
		ST_CRC_BAD     = 3'd4,
		ST_MALFORMED   = 3'd5,
		ST_REJECTED    = 3'd6
	} status_t;

	// One input transfer
	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
	} item_t;

	// Fold one byte into the reflected CRC-32 shift register.
	function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

	// Phase that follows once the given stage has been consumed.
	function automatic phase_t next_phase(input logic [1:0] done, input logic [7:0] flags);
		phase_t ph;
		if (done < DONE_EXTRA && (flags & GZ_FEXTRA) != 8'd0) begin
			ph = PH_XLEN_LO;
		end else if (done < DONE_NAME && (flags & GZ_FNAME) != 8'd0) begin
			ph = PH_NAME;
		end else if (done < DONE_COMMENT && (flags & GZ_FCOMMENT) != 8'd0) begin
			ph = PH_COMMENT;
		end else if ((flags & GZ_FHCRC) != 8'd0) begin
			ph = PH_HCRC_LO;
		end else begin
			ph = PH_PAYLOAD;
		end
		return ph;
	endfunction

endpackage

`default_nettype wire

// File: sv/gzhp_core.sv
// Parse state and per-byte header logic of the gzip header parser.
`default_nettype none

module gzhp_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire gzhp_pkg::item_t  item,
	input  wire logic [15:0]      limit,
	output gzhp_pkg::status_t     status,
	output logic [7:0]            payload,
	output gzhp_pkg::phase_t      phase
);
	import gzhp_pkg::*;

	phase_t      phase_q;
	logic [3:0]  fixed_idx_q;
	logic [7:0]  flags_q;
	logic        fault_q;
	logic [15:0] extra_q;
	logic [15:0] count_q;
	logic [31:0] crc_q;
	logic [7:0]  check_low_q;

	phase_t      cur_phase, phase_n;
	logic [3:0]  cur_idx, idx_n;
	logic [7:0]  cur_flags, flags_n;
	logic        cur_fault, fault_n;
	logic [15:0] cur_extra, extra_n;
	logic [15:0] cur_count, count_n;
	logic [31:0] cur_crc, crc_n, crc_fold_v;
	logic [7:0]  cur_check, check_n;
	status_t     st;
	logic [7:0]  b;

	assign b          = item.data;
	assign crc_fold_v = crc_fold(cur_crc, b);
	assign phase      = phase_q;

	// Start from cleared state when this byte opens a new member
	always_comb begin
		if (item.first) begin
			cur_phase = PH_FIXED;
			cur_idx   = 4'd0;
			cur_flags = 8'd0;
			cur_fault = 1'b0;
			cur_extra = 16'd0;
			cur_count = 16'd0;
			cur_crc   = CRC_INIT;
			cur_check = 8'd0;
		end else begin
			cur_phase = phase_q;
			cur_idx   = fixed_idx_q;
			cur_flags = flags_q;
			cur_fault = fault_q;
			cur_extra = extra_q;
			cur_count = count_q;
			cur_crc   = crc_q;
			cur_check = check_low_q;
		end
	end

	// Next state and status for one byte
	always_comb begin
		phase_n   = cur_phase;
		idx_n     = cur_idx;
		flags_n   = cur_flags;
		fault_n   = cur_fault;
		extra_n   = cur_extra;
		count_n   = cur_count;
		crc_n     = cur_crc;
		check_n   = cur_check;
		st        = ST_PENDING;
		payload   = 8'd0;

		if (cur_phase == PH_PAYLOAD) begin
			st      = ST_PAYLOAD;
			payload = b;
			if (item.last) begin
				phase_n = PH_ENDED;
			end
		end else if (cur_phase == PH_ENDED) begin
			st = ST_REJECTED;
		end else begin
			case (cur_phase)
				PH_FIXED: begin
					crc_n = crc_fold_v;
					if (cur_idx == IDX_ID1 && b != GZ_ID1) fault_n = 1'b1;
					if (cur_idx == IDX_ID2 && b != GZ_ID2) fault_n = 1'b1;
					if (cur_idx == IDX_CM && b != GZ_CM_DEFLATE) fault_n = 1'b1;
					if (cur_idx == IDX_FLAGS) begin
						flags_n = b;
						if ((b & GZ_RESERVED) != 8'd0) fault_n = 1'b1;
					end
					idx_n = cur_idx + 4'd1;
					if (idx_n >= GZ_FIXED_LEN) begin
						if (fault_n) begin
							st = ST_UNSUPPORTED;
						end else begin
							phase_n = next_phase(DONE_FIXED, flags_n);
						end
					end
				end
				PH_XLEN_LO: begin
					crc_n   = crc_fold_v;
					extra_n = {8'd0, b};
					phase_n = PH_XLEN_HI;
				end
				PH_XLEN_HI: begin
					crc_n   = crc_fold_v;
					extra_n = {b, cur_extra[7:0]};
					phase_n = (extra_n == 16'd0) ? next_phase(DONE_EXTRA, cur_flags) : PH_EXTRA;
				end
				PH_EXTRA: begin
					crc_n   = crc_fold_v;
					extra_n = cur_extra - 16'd1;
					if (extra_n == 16'd0) begin
						phase_n = next_phase(DONE_EXTRA, cur_flags);
					end
				end
				PH_NAME, PH_COMMENT: begin
					if (cur_count >= limit) begin
						st = ST_MALFORMED;
					end else begin
						crc_n   = crc_fold_v;
						count_n = cur_count + 16'd1;
						if (b == 8'd0) begin
							count_n = 16'd0;
							phase_n = next_phase((cur_phase == PH_NAME) ? DONE_NAME : DONE_COMMENT,
								cur_flags);
						end else if (count_n >= limit) begin
							st = ST_MALFORMED;
						end
					end
				end
				PH_HCRC_LO: begin
					check_n = b;
					phase_n = PH_HCRC_HI;
				end
				PH_HCRC_HI: begin
					if ({b, cur_check} != ~cur_crc[15:0]) begin
						st = ST_CRC_BAD;
					end else begin
						phase_n = PH_PAYLOAD;
					end
				end
				default: begin
					st = ST_REJECTED;
				end
			endcase

			// Close the member on an error or truncation; a header end reports complete and closes only on the last byte
			if (st != ST_PENDING) begin
				phase_n = PH_ENDED;
			end else if (phase_n == PH_PAYLOAD) begin
				st = ST_COMPLETE;
				if (item.last) begin
					phase_n = PH_ENDED;
				end
			end else if (item.last) begin
				st      = ST_MALFORMED;
				phase_n = PH_ENDED;
			end
		end
		status = st;
	end

	// Commit parse state on each byte handled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FIXED;
			fixed_idx_q <= 4'd0;
			flags_q     <= 8'd0;
			fault_q     <= 1'b0;
			extra_q     <= 16'd0;
			count_q     <= 16'd0;
			crc_q       <= CRC_INIT;
			check_low_q <= 8'd0;
		end else if (step) begin
			phase_q     <= phase_n;
			fixed_idx_q <= idx_n;
			flags_q     <= flags_n;
			fault_q     <= fault_n;
			extra_q     <= extra_n;
			count_q     <= count_n;
			crc_q       <= crc_n;
			check_low_q <= check_n;
		end
	end

endmodule

`default_nettype wire

// File: sv/gzip_header_parser.sv
// Top level of the gzip header parser: channels, pipeline registers and checks.
//
// Usage: bytes of a gzip member enter on the input channel (in_valid/in_ready)
// with first_byte marking the start of a member and last_byte its end. Every
// input transfer yields exactly one result transfer on the output channel
// (out_valid/out_ready) carrying status and payload_byte; payload_byte is the
// input byte when status is payload and zero otherwise.
// The string limit is written through the cfg channel (cfg_valid/cfg_ready),
// which is always ready; write it only while no byte is in flight.
// Path: an input transfer fills the input register, and the parsed result moves
// on into the result register once that is empty or its result is taken.
// Throughput: one byte per cycle while out_ready holds; the CRC-32 byte fold
// and the phase logic both sit in the single stage between the two registers.
// Reset: arst_n clears the parse state to the start of the fixed header, the
// string limit to 1024 and empties both pipeline registers.
// Stall: when out_ready is low with a result held, the input register still
// takes one more byte; in_ready drops only once both registers are full.
`default_nettype none
`include "assert_macros.svh"

module gzip_header_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        first_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [7:0]       payload_byte,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] string_limit
);
	import gzhp_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	logic        valid_s2;
	status_t     status_s2;
	logic [7:0]  payload_s2;
	logic [15:0] limit_q;
	logic        advance;
	logic        step;
	status_t     core_status;
	logic [7:0]  core_payload;
	phase_t      core_phase;

	assign advance   = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign step      = valid_s1 && advance;
	assign cfg_ready = 1'b1;

	// Hold the string limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= string_limit;
		end
	end

	// Input register: capture a transfer whenever the stage frees up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{data: data_byte, first: first_byte, last: last_byte};
		end
	end

	gzhp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.item    (item_s1),
		.limit   (limit_q),
		.status  (core_status),
		.payload (core_payload),
		.phase   (core_phase)
	);

	// Result register: load on advance, drop once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			status_s2  <= core_status;
			payload_s2 <= core_payload;
		end
	end

	assign out_valid    = valid_s2;
	assign status       = status_s2;
	assign payload_byte = payload_s2;

	// Checks
	`ASSERT_CLK(a_payload_zero, clk, arst_n, (valid_s2 && status_s2 != ST_PAYLOAD) |-> (payload_s2 == 8'd0), "payload byte set outside payload status")
	`ASSERT_NEVER(a_ready_only_on_full, clk, arst_n, !in_ready && !(valid_s1 && valid_s2 && !out_ready), "input stalled while pipeline has room")
	`ASSERT_CLK(a_ended_rejects, clk, arst_n, (step && !item_s1.first && core_phase == PH_ENDED) |=> (status_s2 == ST_REJECTED), "byte after member end not rejected")

endmodule

`default_nettype wire
